/* src/rar_pkg.sv */
// shared constants and types for the rational arithmetic reducer
// no dependencies; used by the interfaces and every module in src
package rar_pkg;

  localparam int OPERAND_WIDTH = 16;
  localparam int RES_NUM_W     = 33;
  localparam int RES_DEN_W     = 32;
  localparam int Q_DEPTH       = 2;
  localparam int MUL_STEPS     = 3;

  // operation codes; the unused code decodes as multiply
  localparam logic [1:0] REQ_SUB  = 2'd1;
  localparam logic [1:0] REQ_MUL  = 2'd2;
  localparam logic [1:0] REQ_RSVD = 2'd3;

  // per-item classification made at the front
  typedef struct packed {
    logic err;
    logic mul;
    logic sub;
    logic eq;
  } cls_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUM,
    ST_PREP,
    ST_GCD,
    ST_DIV,
    ST_FIN
  } state_t;

endpackage

/* src/rar_ifs.sv */
// valid/ready channel interfaces for operand items and result items
// depends on rar_pkg for default widths
interface rar_in_if #(
  parameter int W = rar_pkg::OPERAND_WIDTH
);
  logic                valid;
  logic                ready;
  logic [1:0]          req_type;
  logic signed [W-1:0] a_num;
  logic signed [W-1:0] a_den;
  logic signed [W-1:0] b_num;
  logic signed [W-1:0] b_den;

  modport source (output valid, req_type, a_num, a_den, b_num, b_den, input ready);
  modport sink   (input valid, req_type, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rar_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [rar_pkg::RES_NUM_W-1:0] res_num;
  logic signed [rar_pkg::RES_DEN_W-1:0] res_den;
  logic                                zero_den_error;

  modport source (output valid, res_num, res_den, zero_den_error, input ready);
  modport sink   (input valid, res_num, res_den, zero_den_error, output ready);
endinterface

/* src/rar_front.sv */
// front stage: takes operand items, classifies them and hands them to the queue
// depends on rar_pkg and rar_in_if
module rar_front #(
  parameter int OPERAND_WIDTH = rar_pkg::OPERAND_WIDTH
) (
  input  logic                                                  clk,
  input  logic                                                  rst_n,
  rar_in_if.sink                                                in_if,
  output logic                                                  push,
  output logic [$bits(rar_pkg::cls_t)+4*OPERAND_WIDTH-1:0]      push_data,
  input  rar_pkg::q_stat_t                                      q_stat
);

  localparam int W = OPERAND_WIDTH;

  logic                 f_valid_r;
  rar_pkg::cls_t        f_cls_r;
  logic [4*W-1:0]       f_ops_r;
  rar_pkg::cls_t        cls_nxt;
  logic                 take;

  always_comb begin
    cls_nxt.err = (in_if.a_den == '0) || (in_if.b_den == '0);
    cls_nxt.mul = in_if.req_type inside {rar_pkg::REQ_MUL, rar_pkg::REQ_RSVD};
    cls_nxt.sub = (in_if.req_type == rar_pkg::REQ_SUB);
    cls_nxt.eq  = (in_if.a_den == in_if.b_den);
  end

  assign push         = f_valid_r && !q_stat.full;
  assign in_if.ready  = !f_valid_r || push;
  assign take         = in_if.valid && in_if.ready;
  assign push_data    = {f_cls_r, f_ops_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else if (take) begin
      f_valid_r <= 1'b1;
    end else if (push) begin
      f_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      f_cls_r <= cls_nxt;
      f_ops_r <= {in_if.a_num, in_if.a_den, in_if.b_num, in_if.b_den};
    end
  end

endmodule

/* src/rar_queue.sv */
// short fifo between the front and back stages
// depends on rar_pkg for depth and status type
module rar_queue #(
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  input  logic              pop,
  output logic [DATA_W-1:0] pop_data,
  output rar_pkg::q_stat_t  q_stat
);

  localparam int DEPTH = rar_pkg::Q_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW  = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [PW-1:0]     wr_ptr_r;
  logic [PW-1:0]     rd_ptr_r;
  logic [CNTW-1:0]   count_r;
  logic              do_push;
  logic              do_pop;

  assign q_stat.full  = (count_r == CNTW'(DEPTH));
  assign q_stat.empty = (count_r == '0);
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign pop_data     = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* src/rar_back.sv */
// back stage: multiply, cross-scale, binary gcd, exact division, output register
// depends on rar_pkg and rar_out_if
module rar_back #(
  parameter int OPERAND_WIDTH = rar_pkg::OPERAND_WIDTH
) (
  input  logic                                             clk,
  input  logic                                             rst_n,
  input  rar_pkg::q_stat_t                                 q_stat,
  input  logic [$bits(rar_pkg::cls_t)+4*OPERAND_WIDTH-1:0] pop_data,
  output logic                                             pop,
  rar_out_if.source                                        out_if
);

  localparam int W   = OPERAND_WIDTH;
  localparam int DW  = 2 * W;
  localparam int NW  = (2 * W + 1 > 64) ? 64 : 2 * W + 1;
  localparam int CW  = $clog2(NW + 1);
  localparam int NOW = rar_pkg::RES_NUM_W;
  localparam int DOW = rar_pkg::RES_DEN_W;

  rar_pkg::state_t      state_r, state_nxt;
  logic [CW-1:0]        cnt_r;
  logic                 out_valid_r;
  logic                 out_load;

  rar_pkg::cls_t        cls_r;
  logic signed [W-1:0]  an_r, ad_r, bn_r, bd_r;
  logic signed [DW-1:0] p1_r, p2_r, p3_r;
  logic signed [NW-1:0] num_r;
  logic signed [DW-1:0] den_r;
  logic [NW-1:0]        x_r, y_r, g_r;
  logic [CW-1:0]        k_r;
  logic [NW-1:0]        qn_r, qd_r, rn_r, rd_r;
  logic signed [NOW-1:0] res_num_r;
  logic signed [DOW-1:0] res_den_r;
  logic                 err_r;

  rar_pkg::cls_t        q_cls;
  logic signed [W-1:0]  q_an, q_ad, q_bn, q_bd;
  logic signed [W-1:0]  mul_a, mul_b;
  logic signed [DW-1:0] prod;
  logic signed [NW-1:0] num_sum;
  logic [NW-1:0]        mag_n;
  logic [DW-1:0]        mag_d;
  logic [NW:0]          tn, td;
  logic                 ge_n, ge_d;
  logic signed [NW-1:0] qn_s, qd_s;
  logic signed [63:0]   qn64, qd64, raw_n64, raw_d64;

  assign {q_cls, q_an, q_ad, q_bn, q_bd} = pop_data;

  // one shared multiplier, one product per cycle
  always_comb begin
    case (cnt_r)
      CW'(0): begin
        mul_a = an_r;
        mul_b = cls_r.mul ? bn_r : bd_r;
      end
      CW'(1): begin
        mul_a = ad_r;
        mul_b = bn_r;
      end
      default: begin
        mul_a = ad_r;
        mul_b = bd_r;
      end
    endcase
  end
  assign prod = mul_a * mul_b;

  always_comb begin
    if (cls_r.mul) begin
      num_sum = NW'(p1_r);
    end else if (cls_r.eq) begin
      num_sum = cls_r.sub ? NW'(an_r) - NW'(bn_r) : NW'(an_r) + NW'(bn_r);
    end else begin
      num_sum = cls_r.sub ? NW'(p1_r) - NW'(p2_r) : NW'(p1_r) + NW'(p2_r);
    end
  end

  assign mag_n = num_r[NW-1] ? unsigned'(-num_r) : unsigned'(num_r);
  assign mag_d = den_r[DW-1] ? unsigned'(-den_r) : unsigned'(den_r);

  // restoring division lanes, quotient shifts in where the dividend shifts out
  assign tn   = {rn_r, qn_r[NW-1]};
  assign td   = {rd_r, qd_r[NW-1]};
  assign ge_n = (tn >= {1'b0, g_r});
  assign ge_d = (td >= {1'b0, g_r});

  assign qn_s    = num_r[NW-1] ? -signed'(qn_r) : signed'(qn_r);
  assign qd_s    = den_r[DW-1] ? -signed'(qd_r) : signed'(qd_r);
  assign qn64    = 64'(qn_s);
  assign qd64    = 64'(qd_s);
  assign raw_n64 = 64'(num_r);
  assign raw_d64 = 64'(den_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rar_pkg::ST_IDLE: begin
        if (!q_stat.empty) begin
          state_nxt = q_cls.err ? rar_pkg::ST_FIN : rar_pkg::ST_MUL;
        end
      end
      rar_pkg::ST_MUL: begin
        if (cnt_r == CW'(rar_pkg::MUL_STEPS - 1)) begin
          state_nxt = rar_pkg::ST_SUM;
        end
      end
      rar_pkg::ST_SUM:  state_nxt = rar_pkg::ST_PREP;
      rar_pkg::ST_PREP: begin
        state_nxt = (num_r == '0) ? rar_pkg::ST_FIN : rar_pkg::ST_GCD;
      end
      rar_pkg::ST_GCD: begin
        if (x_r == y_r) begin
          state_nxt = rar_pkg::ST_DIV;
        end
      end
      rar_pkg::ST_DIV: begin
        if (cnt_r == CW'(NW - 1)) begin
          state_nxt = rar_pkg::ST_FIN;
        end
      end
      rar_pkg::ST_FIN: begin
        if (out_load) begin
          state_nxt = rar_pkg::ST_IDLE;
        end
      end
      default: state_nxt = rar_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    pop      = 1'b0;
    out_load = 1'b0;
    case (state_r)
      rar_pkg::ST_IDLE: pop      = !q_stat.empty;
      rar_pkg::ST_FIN:  out_load = !out_valid_r || out_if.ready;
      default: begin
        pop      = 1'b0;
        out_load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rar_pkg::ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if ((state_r == rar_pkg::ST_MUL) || (state_r == rar_pkg::ST_DIV)) begin
        cnt_r <= cnt_r + 1'b1;
      end else begin
        cnt_r <= '0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      rar_pkg::ST_IDLE: begin
        if (pop) begin
          cls_r <= q_cls;
          an_r  <= q_an;
          ad_r  <= q_ad;
          bn_r  <= q_bn;
          bd_r  <= q_bd;
        end
      end
      rar_pkg::ST_MUL: begin
        case (cnt_r)
          CW'(0):  p1_r <= prod;
          CW'(1):  p2_r <= prod;
          default: p3_r <= prod;
        endcase
      end
      rar_pkg::ST_SUM: begin
        num_r <= num_sum;
        den_r <= (cls_r.eq && !cls_r.mul) ? DW'(ad_r) : p3_r;
      end
      rar_pkg::ST_PREP: begin
        x_r <= mag_n;
        y_r <= NW'(mag_d);
        k_r <= '0;
      end
      rar_pkg::ST_GCD: begin
        if (x_r == y_r) begin
          g_r  <= x_r << k_r;
          qn_r <= mag_n;
          qd_r <= NW'(mag_d);
          rn_r <= '0;
          rd_r <= '0;
        end else if (!x_r[0] && !y_r[0]) begin
          x_r <= x_r >> 1;
          y_r <= y_r >> 1;
          k_r <= k_r + 1'b1;
        end else if (!x_r[0]) begin
          x_r <= x_r >> 1;
        end else if (!y_r[0]) begin
          y_r <= y_r >> 1;
        end else if (x_r > y_r) begin
          x_r <= (x_r - y_r) >> 1;
        end else begin
          y_r <= (y_r - x_r) >> 1;
        end
      end
      rar_pkg::ST_DIV: begin
        rn_r <= ge_n ? NW'(tn - {1'b0, g_r}) : tn[NW-1:0];
        rd_r <= ge_d ? NW'(td - {1'b0, g_r}) : td[NW-1:0];
        qn_r <= {qn_r[NW-2:0], ge_n};
        qd_r <= {qd_r[NW-2:0], ge_d};
      end
      rar_pkg::ST_FIN: begin
        if (out_load) begin
          err_r <= cls_r.err;
          if (cls_r.err) begin
            res_num_r <= '0;
            res_den_r <= '0;
          end else if (num_r == '0) begin
            // zero numerator leaves the raw denominator in place
            res_num_r <= raw_n64[NOW-1:0];
            res_den_r <= raw_d64[DOW-1:0];
          end else begin
            res_num_r <= qn64[NOW-1:0];
            res_den_r <= qd64[DOW-1:0];
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign out_if.valid          = out_valid_r;
  assign out_if.res_num        = res_num_r;
  assign out_if.res_den        = res_den_r;
  assign out_if.zero_den_error = err_r;

endmodule

/* src/rational_arith_reduce.sv */
// top level of the rational arithmetic reducer: front, queue and back stages
// depends on rar_pkg, rar_ifs, rar_front, rar_queue and rar_back
//
//  channel   dir  handshake      payload
//  in_if     in   valid/ready    req_type, a_num, a_den, b_num, b_den
//  out_if    out  valid/ready    res_num, res_den, zero_den_error
//
// in the back stage an item passes through the idle state, the multiply steps,
// the sum and prep states, up to about 2*NW binary gcd steps plus a final compare,
// NW division steps and the output state, NW = 2*OPERAND_WIDTH+1 capped at 64;
// zero numerators skip from prep, zero denominators from idle, to the output state
// the back sequencer works on one item at a time; the queue holds two more
// reset is synchronous, active low, and empties the queue and output register
// a stalled output holds its item while the back stage starts on the next one
module rational_arith_reduce #(
  parameter int OPERAND_WIDTH = rar_pkg::OPERAND_WIDTH
) (
  input  logic       clk,
  input  logic       rst_n,
  rar_in_if.sink     in_if,
  rar_out_if.source  out_if
);

  localparam int QW = $bits(rar_pkg::cls_t) + 4 * OPERAND_WIDTH;

  logic             push;
  logic [QW-1:0]    push_data;
  logic             pop;
  logic [QW-1:0]    pop_data;
  rar_pkg::q_stat_t q_stat;

  rar_front #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .push      (push),
    .push_data (push_data),
    .q_stat    (q_stat)
  );

  rar_queue #(.DATA_W(QW)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .q_stat    (q_stat)
  );

  rar_back #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_stat   (q_stat),
    .pop_data (pop_data),
    .pop      (pop),
    .out_if   (out_if)
  );

endmodule

/* src/rar_checker.sv */
// port-level checks for the rational arithmetic reducer, bound to the top level
// depends on rar_pkg for result widths
module rar_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_ready,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic signed [rar_pkg::RES_NUM_W-1:0] res_num,
  input logic signed [rar_pkg::RES_DEN_W-1:0] res_den,
  input logic                                 zero_den_error
);

  // an error item carries zero fields
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && zero_den_error |-> (res_num == '0) && (res_den == '0))
    else $error("error item with nonzero fields");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(res_num) && $stable(res_den)
      && $stable(zero_den_error))
    else $error("stalled result changed");

  // after reset the block is empty and ready for an item
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("not empty after reset");

endmodule

bind rational_arith_reduce rar_checker u_rar_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_if.ready),
  .out_valid      (out_if.valid),
  .out_ready      (out_if.ready),
  .res_num        (out_if.res_num),
  .res_den        (out_if.res_den),
  .zero_den_error (out_if.zero_den_error)
);

/* dv/tb_rational_arith_reduce.sv */
// self-checking bench for rational_arith_reduce: drives operand items, predicts the reduced
// fraction of each one and checks every result item field by field, in order
// depends on rar_pkg and rar_ifs from src
module tb_rational_arith_reduce;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int OPW = rar_pkg::OPERAND_WIDTH;
  localparam logic [1:0] REQ_ADD = 2'd0;
  localparam int RANDOM_ITEMS = 2000;
  localparam int PHASE_ITEMS = 300;
  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 200;
  localparam logic signed [OPW-1:0] OP_MIN = {1'b1, {(OPW-1){1'b0}}};
  localparam logic signed [OPW-1:0] OP_MAX = {1'b0, {(OPW-1){1'b1}}};

  typedef struct {
    logic [1:0]            op;
    logic signed [OPW-1:0] a_num;
    logic signed [OPW-1:0] a_den;
    logic signed [OPW-1:0] b_num;
    logic signed [OPW-1:0] b_den;
  } operand_item_t;

  typedef struct {
    logic signed [rar_pkg::RES_NUM_W-1:0] num;
    logic signed [rar_pkg::RES_DEN_W-1:0] den;
    logic                                 err;
  } fraction_t;

  logic clk;
  logic rst_n;

  rar_in_if #(.W(OPW)) in_if ();
  rar_out_if out_if ();

  rational_arith_reduce #(.OPERAND_WIDTH(OPW)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if)
  );

  operand_item_t operand_items[$];
  fraction_t     expected_fractions[$];
  operand_item_t item_on_bus;
  fraction_t     oldest;
  int            sent_count = 0;
  int            error_count = 0;
  int            quiet_cycles;
  int            sender_idle_pct;
  int            receiver_stall_pct;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // exact fraction arithmetic in 64 bits, then a nonzero numerator is reduced by the gcd of the magnitudes
  function automatic fraction_t reduce_fraction(operand_item_t it);
    logic signed [63:0] an, ad, bn, bd, num, den;
    logic [63:0] mn, md, x, y, t, qn, qd;
    fraction_t r;
    an = it.a_num;
    ad = it.a_den;
    bn = it.b_num;
    bd = it.b_den;
    if (ad == 0 || bd == 0) begin
      r.num = '0;
      r.den = '0;
      r.err = 1'b1;
      return r;
    end
    // the unused code has its high bit set and so multiplies
    if (it.op[1]) begin
      num = an * bn;
      den = ad * bd;
    end else if (ad == bd) begin
      den = ad;
      num = (it.op == rar_pkg::REQ_SUB) ? an - bn : an + bn;
    end else begin
      den = ad * bd;
      num = (it.op == rar_pkg::REQ_SUB) ? an * bd - ad * bn : an * bd + ad * bn;
    end
    qn = num;
    qd = den;
    if (num != 0) begin
      mn = num[63] ? -num : num;
      md = den[63] ? -den : den;
      x = mn;
      y = md;
      while (y != 0) begin
        t = x % y;
        x = y;
        y = t;
      end
      mn = mn / x;
      md = md / x;
      qn = num[63] ? -mn : mn;
      qd = den[63] ? -md : md;
    end
    r.num = qn[rar_pkg::RES_NUM_W-1:0];
    r.den = qd[rar_pkg::RES_DEN_W-1:0];
    r.err = 1'b0;
    return r;
  endfunction

  function automatic bit chance(int pct);
    return $urandom_range(99, 0) < pct;
  endfunction

  // mix of extremes, small values that share factors, and the full range
  function automatic logic signed [OPW-1:0] pick_operand();
    logic signed [OPW-1:0] v;
    case ($urandom_range(9, 0))
      0: begin
        case ($urandom_range(4, 0))
          0: v = OP_MIN;
          1: v = OP_MAX;
          2: v = '1;
          3: v = OPW'(1);
          default: v = '0;
        endcase
      end
      1, 2, 3: v = OPW'($signed($urandom_range(24, 0)) - 12);
      4, 5:    v = OPW'($signed($urandom_range(200, 0)) - 100);
      default: v = OPW'($urandom);
    endcase
    return v;
  endfunction

  task automatic queue_item(logic [1:0] op, int an, int ad, int bn, int bd);
    operand_item_t it;
    it.op = op;
    it.a_num = OPW'(an);
    it.a_den = OPW'(ad);
    it.b_num = OPW'(bn);
    it.b_den = OPW'(bd);
    operand_items.push_back(it);
  endtask

  // idling pattern follows the number of items sent so far
  always_comb begin
    case ((sent_count / PHASE_ITEMS) % 4)
      0: begin
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
      end
      1: begin
        sender_idle_pct = 78;
        receiver_stall_pct = 0;
      end
      2: begin
        sender_idle_pct = 0;
        receiver_stall_pct = 78;
      end
      default: begin
        sender_idle_pct = 21;
        receiver_stall_pct = 21;
      end
    endcase
  end

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      in_if.req_type <= REQ_ADD;
      in_if.a_num <= '0;
      in_if.a_den <= '0;
      in_if.b_num <= '0;
      in_if.b_den <= '0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        expected_fractions.push_back(reduce_fraction(item_on_bus));
        sent_count <= sent_count + 1;
      end
      if (!in_if.valid || in_if.ready) begin
        if (operand_items.size() != 0 && !chance(sender_idle_pct)) begin
          item_on_bus = operand_items.pop_front();
          in_if.valid <= 1'b1;
          in_if.req_type <= item_on_bus.op;
          in_if.a_num <= item_on_bus.a_num;
          in_if.a_den <= item_on_bus.a_den;
          in_if.b_num <= item_on_bus.b_num;
          in_if.b_den <= item_on_bus.b_den;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_fractions.size() == 0) begin
          $error("result item with none expected: res_num %0d res_den %0d err %0b",
                 out_if.res_num, out_if.res_den, out_if.zero_den_error);
          error_count++;
        end else begin
          oldest = expected_fractions.pop_front();
          if (out_if.res_num !== oldest.num) begin
            $error("res_num: expected %0d, got %0d", oldest.num, out_if.res_num);
            error_count++;
          end
          if (out_if.res_den !== oldest.den) begin
            $error("res_den: expected %0d, got %0d", oldest.den, out_if.res_den);
            error_count++;
          end
          if (out_if.zero_den_error !== oldest.err) begin
            $error("zero_den_error: expected %0b, got %0b", oldest.err,
                   out_if.zero_den_error);
            error_count++;
          end
        end
      end
      out_if.ready <= !chance(receiver_stall_pct);
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    operand_item_t it;
    rst_n = 1'b0;

    // common denominators kept, otherwise cross-scaled
    queue_item(REQ_ADD, 1, 3, 1, 3);
    queue_item(REQ_ADD, 1, 2, 1, 3);
    queue_item(rar_pkg::REQ_SUB, 5, 6, 1, 4);
    queue_item(rar_pkg::REQ_MUL, 6, 35, 14, 15);
    // zero numerators pass through unreduced
    queue_item(rar_pkg::REQ_SUB, 1, 2, 1, 2);
    queue_item(rar_pkg::REQ_SUB, 1, 2, 2, 4);
    queue_item(rar_pkg::REQ_MUL, 0, 5, 3, 7);
    queue_item(REQ_ADD, 0, -9, 0, -9);
    // negative denominators keep their sign
    queue_item(REQ_ADD, 3, -4, 1, -4);
    queue_item(rar_pkg::REQ_MUL, -2, -6, 3, 9);
    queue_item(rar_pkg::REQ_SUB, -7, 10, 7, -10);
    // zero denominators
    queue_item(REQ_ADD, 1, 0, 1, 2);
    queue_item(rar_pkg::REQ_SUB, 1, 2, 1, 0);
    queue_item(rar_pkg::REQ_MUL, 0, 0, 0, 0);
    // unused code decodes as multiply
    queue_item(rar_pkg::REQ_RSVD, 4, 9, 3, 8);
    queue_item(rar_pkg::REQ_RSVD, OP_MIN, OP_MAX, OP_MAX, OP_MIN);
    // extremes of the operand range
    queue_item(rar_pkg::REQ_MUL, OP_MIN, OP_MIN, OP_MIN, OP_MIN);
    queue_item(rar_pkg::REQ_MUL, OP_MIN, 1, OP_MIN, 1);
    queue_item(REQ_ADD, OP_MIN, OP_MAX, OP_MIN, OP_MIN);
    queue_item(rar_pkg::REQ_SUB, OP_MIN, OP_MAX, OP_MAX, OP_MIN);
    queue_item(REQ_ADD, OP_MAX, -1, OP_MAX, OP_MIN);
    queue_item(rar_pkg::REQ_SUB, OP_MAX, OP_MAX, OP_MIN, OP_MAX);
    queue_item(REQ_ADD, OP_MIN, OP_MIN, OP_MIN, OP_MIN);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      it.op = 2'($urandom_range(3, 0));
      it.a_num = pick_operand();
      it.a_den = pick_operand();
      it.b_num = pick_operand();
      // shared denominators often enough to exercise the common-denominator path
      it.b_den = chance(25) ? it.a_den : pick_operand();
      operand_items.push_back(it);
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (operand_items.size() != 0 || in_if.valid || expected_fractions.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
